// ===== design/ifp_pkg.sv =====
package ifp_pkg;

  localparam logic [7:0] SyncMark = 8'h55;
  localparam logic [7:0] IdAtt    = 8'h01;
  localparam logic [7:0] IdImu    = 8'h03;
  localparam logic [7:0] IdTemp   = 8'h04;
  localparam logic [7:0] LenAtt   = 8'd6;
  localparam logic [7:0] LenImu   = 8'd12;
  localparam logic [7:0] LenTemp  = 8'd8;
  localparam logic [7:0] AttScale = 8'd180;

  localparam logic [1:0] StGood    = 2'd0;
  localparam logic [1:0] StNoDec   = 2'd1;
  localparam logic [1:0] StSumErr  = 2'd2;
  localparam logic [1:0] StLenErr  = 2'd3;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindAtt  = 2'd1;
  localparam logic [1:0] KindImu  = 2'd2;
  localparam logic [1:0] KindTemp = 2'd3;

  localparam logic [0:0] RegAccel = 1'b0;
  localparam logic [0:0] RegGyro  = 1'b1;

  // frame end record passed from the parser to the decoder
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [7:0]  ident;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [15:0] w4;
    logic [15:0] w5;
    logic [31:0] good;
    logic [31:0] bad;
  } frame_t;

endpackage

// ===== design/ifp_front.sv =====
module ifp_front #(
  parameter int MaxPayload = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [7:0]           byte_i,
  output logic                 valid_o,
  output ifp_pkg::frame_t      frame_o
);

  localparam int IdxW = $clog2(MaxPayload + 1);

  localparam logic [2:0] PhSync1 = 3'd0;
  localparam logic [2:0] PhSync2 = 3'd1;
  localparam logic [2:0] PhId    = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhCheck = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic [31:0]     good_q, good_d, bad_q, bad_d;
  logic [7:0]      store_q [12];
  logic            emit;
  ifp_pkg::frame_t frm;

  always_comb begin
    phase_d = phase_q;
    id_d = id_q;
    len_d = len_q;
    idx_d = idx_q;
    sum_d = sum_q;
    good_d = good_q;
    bad_d = bad_q;
    emit = 1'b0;
    frm = '0;
    if (valid_i) begin
      unique case (phase_q)
        PhSync2: begin
          if (byte_i == ifp_pkg::SyncMark) begin
            sum_d = sum_q + byte_i;
            phase_d = PhId;
          end else begin
            phase_d = PhSync1;
            sum_d = '0;
            idx_d = '0;
          end
        end
        PhId: begin
          id_d = byte_i;
          sum_d = sum_q + byte_i;
          phase_d = PhLen;
        end
        PhLen: begin
          if (32'(byte_i) > 32'(MaxPayload)) begin
            bad_d = bad_q + 32'd1;
            phase_d = PhSync1;
            sum_d = '0;
            idx_d = '0;
            emit = 1'b1;
            frm.status = ifp_pkg::StLenErr;
          end else begin
            len_d = byte_i;
            sum_d = sum_q + byte_i;
            idx_d = '0;
            phase_d = (byte_i == 8'd0) ? PhCheck : PhData;
          end
        end
        PhData: begin
          idx_d = idx_q + IdxW'(1);
          sum_d = sum_q + byte_i;
          if (8'(idx_d) >= len_q) phase_d = PhCheck;
        end
        PhCheck: begin
          emit = 1'b1;
          frm.ident = id_q;
          if (byte_i != sum_q) begin
            bad_d = bad_q + 32'd1;
            frm.status = ifp_pkg::StSumErr;
          end else begin
            good_d = good_q + 32'd1;
            frm.status = ifp_pkg::StNoDec;
            if (id_q == ifp_pkg::IdAtt && len_q == ifp_pkg::LenAtt) begin
              frm.status = ifp_pkg::StGood;
              frm.kind = ifp_pkg::KindAtt;
            end else if (id_q == ifp_pkg::IdImu && len_q == ifp_pkg::LenImu) begin
              frm.status = ifp_pkg::StGood;
              frm.kind = ifp_pkg::KindImu;
            end else if (id_q == ifp_pkg::IdTemp && len_q == ifp_pkg::LenTemp) begin
              frm.status = ifp_pkg::StGood;
              frm.kind = ifp_pkg::KindTemp;
            end
          end
          frm.w0 = {store_q[1], store_q[0]};
          frm.w1 = {store_q[3], store_q[2]};
          frm.w2 = {store_q[5], store_q[4]};
          frm.w3 = {store_q[7], store_q[6]};
          frm.w4 = {store_q[9], store_q[8]};
          frm.w5 = {store_q[11], store_q[10]};
          phase_d = PhSync1;
          sum_d = '0;
          idx_d = '0;
        end
        default: begin
          if (byte_i == ifp_pkg::SyncMark) begin
            sum_d = byte_i;
            phase_d = PhSync2;
          end else begin
            phase_d = PhSync1;
            sum_d = '0;
            idx_d = '0;
          end
        end
      endcase
    end
    frm.good = good_d;
    frm.bad = bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync1;
      id_q <= '0;
      len_q <= '0;
      idx_q <= '0;
      sum_q <= '0;
      good_q <= '0;
      bad_q <= '0;
      valid_o <= 1'b0;
    end else begin
      phase_q <= phase_d;
      id_q <= id_d;
      len_q <= len_d;
      idx_q <= idx_d;
      sum_q <= sum_d;
      good_q <= good_d;
      bad_q <= bad_d;
      valid_o <= emit;
    end
  end

  // only the first twelve payload bytes are ever decoded
  always_ff @(posedge clk_i) begin
    if (valid_i && phase_q == PhData && idx_q < IdxW'(12)) begin
      store_q[idx_q[3:0]] <= byte_i;
    end
    frame_o <= frm;
  end

  property p_cnt_step;
    @(posedge clk_i) disable iff (!rst_ni)
      valid_o |-> (good_q - $past(good_q)) + (bad_q - $past(bad_q)) == 32'd1;
  endproperty
  a_cnt_step: assert property (p_cnt_step) else $error("counter step");

  a_no_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !valid_o |-> good_q == $past(good_q) && bad_q == $past(bad_q))
    else $error("counter moved");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
      phase_q == PhData |-> 32'(len_q) <= 32'(MaxPayload))
    else $error("length");

endmodule

// ===== design/ifp_back.sv =====
module ifp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ifp_pkg::frame_t frame_i,
  input  logic [14:0]     accel_scale_i,
  input  logic [14:0]     gyro_scale_i,
  output logic            valid_o,
  output logic [1:0]      status_o,
  output logic [1:0]      kind_o,
  output logic [7:0]      ident_o,
  output logic [30:0]     val_o [6],
  output logic [31:0]     good_o,
  output logic [31:0]     bad_o
);

  logic signed [15:0] w [6];
  logic signed [15:0] m [6];
  logic signed [30:0] p [6];

  assign w[0] = frame_i.w0;
  assign w[1] = frame_i.w1;
  assign w[2] = frame_i.w2;
  assign w[3] = frame_i.w3;
  assign w[4] = frame_i.w4;
  assign w[5] = frame_i.w5;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      m[i] = '0;
      p[i] = '0;
    end
    if (frame_i.status == ifp_pkg::StGood) begin
      unique case (frame_i.kind)
        ifp_pkg::KindAtt: begin
          for (int i = 0; i < 3; i++) m[i] = {8'd0, ifp_pkg::AttScale};
        end
        ifp_pkg::KindImu: begin
          for (int i = 0; i < 3; i++) begin
            m[i] = {1'b0, accel_scale_i};
            m[i+3] = {1'b0, gyro_scale_i};
          end
        end
        ifp_pkg::KindTemp: m[3] = 16'sd1;
        default: ;
      endcase
    end
    // drop unused words so stale payload never reaches the result
    for (int i = 0; i < 6; i++) begin
      if (m[i] != '0) p[i] = 31'(32'(w[i]) * 32'(m[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    status_o <= frame_i.status;
    kind_o <= frame_i.kind;
    ident_o <= frame_i.ident;
    good_o <= frame_i.good;
    bad_o <= frame_i.bad;
    for (int i = 0; i < 6; i++) val_o[i] <= p[i];
  end

endmodule

// ===== design/ifp_fifo.sv =====
module ifp_fifo #(
  parameter int Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [1:0]  status_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  ident_i,
  input  logic [30:0] val_i [6],
  input  logic [31:0] good_i,
  input  logic [31:0] bad_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic        afull_o,
  output logic [1:0]  status_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  ident_o,
  output logic [30:0] val_o [6],
  output logic [31:0] good_o,
  output logic [31:0] bad_o
);

  localparam int AW = $clog2(Depth);
  localparam int W = 2 + 2 + 8 + 6 * 31 + 64;

  logic [W-1:0]  mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic [W-1:0]  wd, rd;
  logic          do_pop;

  assign wd = {status_i, kind_i, ident_i, val_i[0], val_i[1], val_i[2],
               val_i[3], val_i[4], val_i[5], good_i, bad_i};
  assign rd = mem_q[rp_q];
  assign {status_o, kind_o, ident_o, val_o[0], val_o[1], val_o[2],
          val_o[3], val_o[4], val_o[5], good_o, bad_o} = rd;
  assign empty_o = (cnt_q == '0);
  assign do_pop = pop_i && !empty_o;
  // leave room for items already in the front and back stages
  assign afull_o = (cnt_q >= (AW+1)'(Depth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (do_pop) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wd;
  end

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
      push_i |-> cnt_q < (AW+1)'(Depth) || do_pop)
    else $error("overflow");

endmodule

// ===== design/imu_frame_parser_unit.sv =====
// channel | direction | handshake          | payload
// in      | to block  | push / full        | rx_byte_i
// result  | from block| empty / pop        | frame_status_o .. bad_total_o
// config  | to block  | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
// One byte is taken per cycle while full is low; a frame result passes through the
// parser, multiplier stage and result queue registers before it reaches the outputs.
// full rises when the four-entry result queue nears capacity, since a result
// may still be in flight in the parser and multiplier stages.
// Reset clears the parser, counters and queue; scale registers return to 4 and 2000.
module imu_frame_parser_unit #(
  parameter int MaxPayload = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         frame_status_o,
  output logic [1:0]         frame_kind_o,
  output logic [7:0]         frame_ident_o,
  output logic signed [30:0] value_a_o,
  output logic signed [30:0] value_b_o,
  output logic signed [30:0] value_c_o,
  output logic signed [30:0] value_d_o,
  output logic signed [30:0] value_e_o,
  output logic signed [30:0] value_f_o,
  output logic [31:0]        good_total_o,
  output logic [31:0]        bad_total_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i
);

  logic [14:0]     accel_q, gyro_q;
  logic            acc, fv, bv;
  ifp_pkg::frame_t frm;
  logic [1:0]      bst, bkd;
  logic [7:0]      bid;
  logic [30:0]     bval [6];
  logic [30:0]     qval [6];
  logic [31:0]     bgood, bbad;

  assign cfg_ready_o = 1'b1;
  assign acc = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= 15'd4;
      gyro_q <= 15'd2000;
    end else if (cfg_valid_i && cfg_data_i != '0) begin
      unique case (cfg_index_i)
        ifp_pkg::RegAccel: accel_q <= cfg_data_i;
        ifp_pkg::RegGyro:  gyro_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ifp_front #(.MaxPayload(MaxPayload)) u_front (
    .clk_i, .rst_ni, .valid_i(acc), .byte_i(rx_byte_i), .valid_o(fv), .frame_o(frm)
  );

  ifp_back u_back (
    .clk_i, .rst_ni, .valid_i(fv), .frame_i(frm),
    .accel_scale_i(accel_q), .gyro_scale_i(gyro_q),
    .valid_o(bv), .status_o(bst), .kind_o(bkd), .ident_o(bid),
    .val_o(bval), .good_o(bgood), .bad_o(bbad)
  );

  ifp_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni, .push_i(bv), .status_i(bst), .kind_i(bkd), .ident_i(bid),
    .val_i(bval), .good_i(bgood), .bad_i(bbad), .pop_i(pop),
    .empty_o(empty), .afull_o(full),
    .status_o(frame_status_o), .kind_o(frame_kind_o), .ident_o(frame_ident_o),
    .val_o(qval), .good_o(good_total_o), .bad_o(bad_total_o)
  );

  assign value_a_o = qval[0];
  assign value_b_o = qval[1];
  assign value_c_o = qval[2];
  assign value_d_o = qval[3];
  assign value_e_o = qval[4];
  assign value_f_o = qval[5];

endmodule
